// File: src/rgb_to_hsv_pixel_core_macros.svh
// Assertion macros for the RGB to HSV pixel core checker.
// No dependencies; included by the checker file only.
`ifndef RGB_TO_HSV_PIXEL_CORE_MACROS_SVH
`define RGB_TO_HSV_PIXEL_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HSV_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define HSV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/hsv_pkg.sv
// Shared types, constants and the divider step for the RGB to HSV core.
// No dependencies.
package hsv_pkg;

  localparam int unsigned ChanW = 8;

  // Hue angles in degrees
  localparam logic [8:0]        HueSectorDeg  = 9'd60;
  localparam logic signed [7:0] HueSectorDegS = 8'(signed'(HueSectorDeg));
  localparam logic [8:0]        HueGreenBase  = 9'd120;
  localparam logic [8:0]        HueBlueBase   = 9'd240;
  localparam logic [8:0]        HueFullTurn   = 9'd360;
  localparam logic [7:0]        SatScale      = 8'd255;

  // Restoring divider: one quotient bit per step
  localparam int unsigned DivSteps         = ChanW;
  localparam int unsigned DivStepsPerStage = 2;
  localparam int unsigned DivStages        = DivSteps / DivStepsPerStage;

  // First field in the highest bits of tdata
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } hsv_pix_t;

  typedef struct packed {
    logic [ChanW-1:0]  mx;
    logic [ChanW-1:0]  d;
    logic [8:0]        base;
    logic signed [8:0] diff;
  } hsv_s1_t;

  typedef struct packed {
    logic [ChanW-1:0] mx;
    logic [7:0]       sat_rem;
    logic [7:0]       sat_lo;
    logic [7:0]       sat_den;
    logic [7:0]       sat_q;
    logic [8:0]       hue_rem;
    logic [7:0]       hue_lo;
    logic [8:0]       hue_den;
    logic [7:0]       hue_q;
  } hsv_div_t;

  // One restoring step on both quotients; remainders stay below their divisors
  function automatic hsv_div_t hsv_div_step(hsv_div_t x);
    hsv_div_t   y;
    logic [8:0] sat_t;
    logic [9:0] hue_t;
    y      = x;
    sat_t  = {x.sat_rem, x.sat_lo[7]};
    hue_t  = {x.hue_rem, x.hue_lo[7]};
    y.sat_lo = {x.sat_lo[6:0], 1'b0};
    y.hue_lo = {x.hue_lo[6:0], 1'b0};
    if (sat_t >= {1'b0, x.sat_den}) begin
      y.sat_rem = 8'(sat_t - {1'b0, x.sat_den});
      y.sat_q   = {x.sat_q[6:0], 1'b1};
    end else begin
      y.sat_rem = sat_t[7:0];
      y.sat_q   = {x.sat_q[6:0], 1'b0};
    end
    if (hue_t >= {1'b0, x.hue_den}) begin
      y.hue_rem = 9'(hue_t - {1'b0, x.hue_den});
      y.hue_q   = {x.hue_q[6:0], 1'b1};
    end else begin
      y.hue_rem = hue_t[8:0];
      y.hue_q   = {x.hue_q[6:0], 1'b0};
    end
    return y;
  endfunction

endpackage

// File: src/hsv_minmax.sv
// Stage 1: max, min, delta and hue sector selection of one pixel.
// Depends on hsv_pkg.
module hsv_minmax
  import hsv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  hsv_pix_t pix_i,
  output logic     valid_o,
  output hsv_s1_t  data_o
);

  logic       valid_q;
  hsv_s1_t    data_d, data_q;
  logic [7:0] mx, mn;

  always_comb begin
    mx = (pix_i.red >= pix_i.green) ? pix_i.red : pix_i.green;
    mx = (mx >= pix_i.blue) ? mx : pix_i.blue;
    mn = (pix_i.red <= pix_i.green) ? pix_i.red : pix_i.green;
    mn = (mn <= pix_i.blue) ? mn : pix_i.blue;
    data_d.mx = mx;
    data_d.d  = mx - mn;
    // Ties: red first, then green, then blue
    if (mx == pix_i.red) begin
      data_d.diff = $signed({1'b0, pix_i.green}) - $signed({1'b0, pix_i.blue});
      data_d.base = data_d.diff[8] ? HueFullTurn : '0;
    end else if (mx == pix_i.green) begin
      data_d.diff = $signed({1'b0, pix_i.blue}) - $signed({1'b0, pix_i.red});
      data_d.base = HueGreenBase;
    end else begin
      data_d.diff = $signed({1'b0, pix_i.red}) - $signed({1'b0, pix_i.green});
      data_d.base = HueBlueBase;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: src/hsv_numer.sv
// Stage 2: dividends and divisors for saturation and hue.
// Depends on hsv_pkg.
module hsv_numer
  import hsv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  hsv_s1_t  data_i,
  output logic     valid_o,
  output hsv_div_t data_o
);

  logic               valid_q;
  hsv_div_t           data_d, data_q;
  logic [15:0]        sat_num;
  logic [16:0]        base_prod;
  logic signed [17:0] side_s;
  logic signed [17:0] num_s;
  logic [16:0]        hue_num;

  always_comb begin
    sat_num   = 16'(data_i.d) * 16'(SatScale);
    base_prod = 17'(data_i.base) * 17'(data_i.d);
    side_s    = 18'(data_i.diff) * 18'(HueSectorDegS);
    // Never negative: the base absorbs a negative red-sector angle
    num_s     = $signed({1'b0, base_prod}) + side_s;
    hue_num   = num_s[16:0];

    data_d.mx      = data_i.mx;
    // Quotients fit 8 bits, so the top bits already sit below the divisor
    data_d.sat_rem = sat_num[15:8];
    data_d.sat_lo  = sat_num[7:0];
    data_d.sat_den = (data_i.mx == '0) ? 8'd1 : data_i.mx;
    data_d.sat_q   = '0;
    data_d.hue_rem = hue_num[16:8];
    data_d.hue_lo  = hue_num[7:0];
    data_d.hue_den = (data_i.d == '0) ? 9'd1 : {data_i.d, 1'b0};
    data_d.hue_q   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: src/hsv_divstage.sv
// Divider pipeline stage: a few restoring steps on both quotients.
// Depends on hsv_pkg.
module hsv_divstage
  import hsv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  hsv_div_t data_i,
  output logic     valid_o,
  output hsv_div_t data_o
);

  logic     valid_q;
  hsv_div_t data_d, data_q;

  always_comb begin
    data_d = data_i;
    for (int i = 0; i < DivStepsPerStage; i++) begin
      data_d = hsv_div_step(data_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: src/rgb_to_hsv_pixel_core.sv
// RGB to HSV pixel core, hue in half degrees. Depends on hsv_pkg and the stage modules.
// Stages from input beat to output beat: min/max, dividends, 4 divider stages, each registered.
// Throughput: one pixel per cycle; the whole pipeline holds when the output stalls.
// Reset clears all stage valid bits; no clearing pass, ready as soon as reset is released.
module rgb_to_hsv_pixel_core
  import hsv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // blue [7:0], green [15:8], red [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // hue [7:0], saturation [15:8], brightness [23:16]
);

  logic     en;
  logic     s1_valid, s2_valid;
  hsv_s1_t  s1_data;
  logic     div_valid [DivStages+1];
  hsv_div_t div_data  [DivStages+1];

  // Global stall: advance when the output slot is empty or being taken
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  hsv_minmax u_minmax (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .pix_i   (hsv_pix_t'(s_axis_tdata)),
    .valid_o (s1_valid),
    .data_o  (s1_data)
  );

  hsv_numer u_numer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .data_o  (div_data[0])
  );

  assign div_valid[0] = s2_valid;

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    hsv_divstage u_divstage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_valid[g]),
      .data_i  (div_data[g]),
      .valid_o (div_valid[g+1]),
      .data_o  (div_data[g+1])
    );
  end

  assign m_axis_tvalid = div_valid[DivStages];
  assign m_axis_tdata  = {div_data[DivStages].mx,
                          div_data[DivStages].sat_q,
                          div_data[DivStages].hue_q};

endmodule

// File: src/hsv_checker.sv
// Port-level checks for the RGB to HSV pixel core, bound to the top level.
// Depends on rgb_to_hsv_pixel_core_macros.svh.
`include "rgb_to_hsv_pixel_core_macros.svh"

module hsv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  logic unused_in;
  assign unused_in = s_axis_tvalid ^ (^s_axis_tdata);

  // A stalled output beat stays put
  `HSV_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")

  // With the output slot empty the pipeline must take input
  `HSV_ASSERT_NOW(a_ready_free, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

  // Half-degree hue never reaches 180
  `HSV_ASSERT_NOW(a_hue_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[7:0] <= 8'd179, "hue out of range")

  // Zero saturation means a grey pixel, hence zero hue
  `HSV_ASSERT_NOW(a_grey_hue, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[15:8] == 8'd0), m_axis_tdata[7:0] == 8'd0, "grey pixel with non-zero hue")

endmodule

bind rgb_to_hsv_pixel_core hsv_checker u_hsv_checker (.*);

// File: dv/tb_top.sv
// Self-checking testbench for rgb_to_hsv_pixel_core: random and directed pixels go in on
// the slave stream, and each HSV beat is checked against an in-bench integer predictor.
// Depends on hsv_pkg and the core RTL.
module tb_top
  import hsv_pkg::*;
();

  localparam int PIPE_LATENCY = 6;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 64;
  localparam int REPORT_LIMIT = 10;

  // hue lowest, as on m_axis_tdata
  typedef struct packed {
    logic [ChanW-1:0] brightness;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] hue;
  } hsv_res_t;

  typedef struct {
    hsv_pix_t px;
    hsv_res_t res;
  } hsv_pending_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // blue [7:0], green [15:8], red [23:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // hue [7:0], saturation [15:8], brightness [23:16]

  hsv_pending_t pending_hsv[$];
  int fault_count        = 0;
  int pixels_sent        = 0;
  int results_checked    = 0;
  int input_stall_cycles = 0;
  int idle_cycles        = 0;
  bit idling             = 1'b1;
  bit hold_req           = 1'b0;

  rgb_to_hsv_pixel_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic note_failure(input string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  function automatic hsv_pix_t rgb(input int unsigned r, input int unsigned g,
                                   input int unsigned b);
    hsv_pix_t px;
    px.red   = r[7:0];
    px.green = g[7:0];
    px.blue  = b[7:0];
    return px;
  endfunction

  // Exact integer HSV: angle is kept as a numerator over delta, then halved
  function automatic hsv_res_t predict_hsv(input hsv_pix_t px);
    int unsigned r, g, b, mx, mn, d, angle;
    hsv_res_t    res;
    r   = px.red;
    g   = px.green;
    b   = px.blue;
    mx  = (r > g) ? r : g;
    mx  = (mx > b) ? mx : b;
    mn  = (r < g) ? r : g;
    mn  = (mn < b) ? mn : b;
    d   = mx - mn;
    res = '0;
    res.brightness = mx[7:0];
    if (mx != 0) res.saturation = 8'((SatScale * d) / mx);
    if (d != 0) begin
      // red wins ties, then green
      if (mx == r) begin
        angle = (g >= b) ? HueSectorDeg * (g - b)
                         : HueFullTurn * d - HueSectorDeg * (b - g);
      end else if (mx == g) begin
        angle = (b >= r) ? HueGreenBase * d + HueSectorDeg * (b - r)
                         : HueGreenBase * d - HueSectorDeg * (r - b);
      end else begin
        angle = (r >= g) ? HueBlueBase * d + HueSectorDeg * (r - g)
                         : HueBlueBase * d - HueSectorDeg * (g - r);
      end
      res.hue = 8'(angle / (2 * d));
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!idling) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Samples are taken before this edge's updates land, so both sides see pre-edge values
  always @(posedge clk_i) begin
    hsv_pending_t oldest;
    hsv_pending_t fresh;
    hsv_res_t     got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        fresh.px    = hsv_pix_t'(s_axis_tdata);
        fresh.res   = predict_hsv(fresh.px);
        pending_hsv = {pending_hsv, fresh};
      end
      if (s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        got = hsv_res_t'(m_axis_tdata);
        if (pending_hsv.size() == 0) begin
          note_failure($sformatf("unexpected HSV beat %06h with nothing pending",
                                 m_axis_tdata));
        end else begin
          oldest = pending_hsv.pop_front();
          results_checked++;
          if (got.hue !== oldest.res.hue || got.saturation !== oldest.res.saturation ||
              got.brightness !== oldest.res.brightness)
            note_failure($sformatf(
              "rgb %0d/%0d/%0d: expected h/s/v %0d/%0d/%0d, got %0d/%0d/%0d",
              oldest.px.red, oldest.px.green, oldest.px.blue, oldest.res.hue,
              oldest.res.saturation, oldest.res.brightness, got.hue, got.saturation,
              got.brightness));
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                   idle_cycles, pending_hsv.size());
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    int span;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!idling || $urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
        span = $urandom_range(1, 8);
        repeat (span) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        span = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        repeat (span) @(posedge clk_i);
      end
    end
  end

  // tvalid stays high across back-to-back beats; it is only dropped for a real gap
  task automatic send_pixel(input hsv_pix_t px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixels_sent++;
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_hsv.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_pixel(rgb(0, 0, 0));         // black
    send_pixel(rgb(255, 255, 255));
    send_pixel(rgb(128, 128, 128));   // grey
    send_pixel(rgb(1, 1, 1));
    send_pixel(rgb(255, 0, 0));
    send_pixel(rgb(0, 255, 0));
    send_pixel(rgb(0, 0, 255));
    send_pixel(rgb(255, 255, 0));     // red/green tie
    send_pixel(rgb(255, 0, 255));     // red/blue tie
    send_pixel(rgb(0, 255, 255));     // green/blue tie
    send_pixel(rgb(200, 200, 10));
    send_pixel(rgb(10, 200, 200));
    send_pixel(rgb(200, 10, 200));
    send_pixel(rgb(255, 0, 1));       // tiny negative angle, wraps to 179
    send_pixel(rgb(100, 200, 0));
    send_pixel(rgb(0, 200, 100));
    send_pixel(rgb(100, 0, 200));
    send_pixel(rgb(0, 100, 200));
    send_pixel(rgb(255, 254, 254));
    send_pixel(rgb(1, 0, 0));
    send_pixel(rgb(8'hAA, 8'h55, 8'hAA));
    send_pixel(rgb(8'h55, 8'hAA, 8'h55));
    send_pixel(rgb(0, 0, 1));
    wait_results_drained();
  endtask

  task automatic test_uniform(input int count);
    repeat (count)
      send_pixel(rgb($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255)));
    wait_results_drained();
  endtask

  // Two levels per pixel: lots of max ties and some grey
  task automatic test_ties(input int count);
    int unsigned lo, hi;
    repeat (count) begin
      lo = $urandom_range(0, 255);
      hi = $urandom_range(0, 255);
      send_pixel(rgb($urandom_range(0, 1) ? hi : lo, $urandom_range(0, 1) ? hi : lo,
                     $urandom_range(0, 1) ? hi : lo));
    end
    wait_results_drained();
  endtask

  // Small deltas stress the hue division near sector edges
  task automatic test_near_gray(input int count);
    int base;
    int ch[3];
    repeat (count) begin
      base = $urandom_range(0, 255);
      foreach (ch[i]) begin
        ch[i] = base + int'($urandom_range(0, 6)) - 3;
        if (ch[i] < 0) ch[i] = 0;
        if (ch[i] > 255) ch[i] = 255;
      end
      send_pixel(rgb(ch[0], ch[1], ch[2]));
    end
    wait_results_drained();
  endtask

  task automatic test_full_rate(input int count);
    idling = 1'b0;
    test_uniform(count);
    idling = 1'b1;
  endtask

  // Output held off while input keeps coming, so the pipe fills and stalls upstream
  task automatic test_backpressure(input int count);
    idling   = 1'b0;
    hold_req = 1'b1;
    test_uniform(count);
    idling   = 1'b1;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_uniform(360);
    test_backpressure(40);
    test_ties(140);
    test_near_gray(140);
    test_full_rate(100);

    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
    if (pending_hsv.size() != 0)
      note_failure($sformatf("%0d HSV results never arrived", pending_hsv.size()));

    $display("Run: %0d pixels in, %0d HSV beats checked (corners, ties, near-grey, bursts).",
             pixels_sent, results_checked);
    $display("Input stalled for %0d cycles under output hold-off; %0d failures.",
             input_stall_cycles, fault_count);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/hsv_pkg.sv
src/hsv_minmax.sv
src/hsv_numer.sv
src/hsv_divstage.sv
src/rgb_to_hsv_pixel_core.sv
src/hsv_checker.sv
dv/tb_top.sv
